// ===== src/sha1s_pkg.sv =====
package sha1s_pkg;

   // Input item codes
   localparam logic [1:0] ACT_RESTART = 2'd0;
   localparam logic [1:0] ACT_ABSORB  = 2'd1;
   localparam logic [1:0] ACT_FINISH  = 2'd2;

   // Result status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_TOO_LONG  = 2'd1;
   localparam logic [1:0] STS_STATE_ERR = 2'd2;

   // Block geometry
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;
   localparam logic [6:0] LAST_ROUND    = 7'd79;
   localparam logic [2:0] LAST_WORD     = 3'd4;
   localparam logic [2:0] LAST_LEN_BYTE = 3'd7;

   localparam logic [7:0]  PAD_MARK  = 8'h80;
   localparam logic [63:0] COUNT_TOP = 64'hFFFF_FFFF_FFFF_FFF8;

   localparam logic [31:0] INIT_WORDS [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };
   localparam logic [31:0] ROUND_K [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_LEN,
      S_ROUND,
      S_ADD,
      S_EMIT,
      S_EMIT_ERR
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic         restart;
      logic         shift_en;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         count_en;
      logic         count_clear;
      logic         load_vars;
      logic         round_en;
      logic [1:0]   phase;
      logic         add_chain;
      logic         rsp_load;
      logic         rsp_error;
      logic [2:0]   rsp_index;
      logic [1:0]   rsp_status;
      logic         rsp_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic count_top;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== src/sha1s_datapath.sv =====
module sha1s_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        data_byte,
   input  sha1s_pkg::cmd_type cmd,
   output sha1s_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sha1s_pkg::rsp_type rsp_payload
);

   logic [31:0] ring_ff [16];
   logic [31:0] ring_in [16];
   logic [31:0] vars_ff [5];
   logic [31:0] vars_in [5];
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [63:0] count_ff;
   logic [63:0] count_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   sha1s_pkg::rsp_type rsp_ff;
   sha1s_pkg::rsp_type rsp_in;

   logic [7:0]  byte_mux;
   logic [31:0] sched_next;
   logic [31:0] f_val;
   logic [31:0] tmp_val;
   logic [31:0] va, vb, vc, vd, ve;

   assign va = vars_ff[0];
   assign vb = vars_ff[1];
   assign vc = vars_ff[2];
   assign vd = vars_ff[3];
   assign ve = vars_ff[4];

   // Pick the byte that enters the block
   always_comb begin
      unique case (cmd.byte_sel)
         sha1s_pkg::SEL_MSG:  byte_mux = data_byte;
         sha1s_pkg::SEL_PAD:  byte_mux = sha1s_pkg::PAD_MARK;
         sha1s_pkg::SEL_ZERO: byte_mux = 8'h00;
         sha1s_pkg::SEL_LEN:  byte_mux = count_ff[{~cmd.len_idx, 3'b000} +: 8];
         default:             byte_mux = 8'h00;
      endcase
   end

   // Round logic: schedule word and mixing function
   assign sched_next = ring_ff[13] ^ ring_ff[8] ^ ring_ff[2] ^ ring_ff[0];

   always_comb begin
      case (cmd.phase)
         2'd0:    f_val = (vb & vc) | (~vb & vd);
         2'd2:    f_val = (vb & vc) | (vb & vd) | (vc & vd);
         default: f_val = vb ^ vc ^ vd;
      endcase
   end

   assign tmp_val = {va[26:0], va[31:27]} + f_val + ve + ring_ff[0]
                    + sha1s_pkg::ROUND_K[cmd.phase];

   // Block buffer and schedule ring share one 16-word shift line
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         ring_in[i] = ring_ff[i];
      end
      if (cmd.shift_en) begin
         for (int i = 0; i < 15; i++) begin
            ring_in[i] = {ring_ff[i][23:0], ring_ff[i + 1][31:24]};
         end
         ring_in[15] = {ring_ff[15][23:0], byte_mux};
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            ring_in[i] = ring_ff[i + 1];
         end
         ring_in[15] = {sched_next[30:0], sched_next[31]};
      end
   end

   // Working variables and chaining value
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         vars_in[i]  = vars_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (cmd.load_vars) begin
         for (int i = 0; i < 5; i++) begin
            vars_in[i] = chain_ff[i];
         end
      end else if (cmd.round_en) begin
         vars_in[0] = tmp_val;
         vars_in[1] = va;
         vars_in[2] = {vb[1:0], vb[31:2]};
         vars_in[3] = vc;
         vars_in[4] = vd;
      end
      if (cmd.restart) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = sha1s_pkg::INIT_WORDS[i];
         end
      end else if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
   end

   // Message bit count
   always_comb begin
      count_in = count_ff;
      if (cmd.restart || cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_en) begin
         count_in = count_ff + 64'd8;
      end
   end

   // Result register: load a word, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.digest_word = cmd.rsp_error ? 32'd0 : chain_ff[cmd.rsp_index];
         rsp_in.word_index  = cmd.rsp_index;
         rsp_in.status      = cmd.rsp_status;
         rsp_in.last        = cmd.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= sha1s_pkg::INIT_WORDS[i];
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_ff <= ring_in;
      vars_ff <= vars_in;
      rsp_ff  <= rsp_in;
   end

   assign sts.count_top = (count_ff == sha1s_pkg::COUNT_TOP);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

endmodule

// ===== src/sha1s_ctrl.sv =====
module sha1s_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_accept,
   input  logic [1:0]         action,
   output logic               req_ready,
   input  sha1s_pkg::sts_type sts,
   output sha1s_pkg::cmd_type cmd
);

   sha1s_pkg::state_type state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] len_ff, len_in;
   logic [2:0] idx_ff, idx_in;
   logic       finished_ff, finished_in;
   logic [1:0] error_ff, error_in;
   logic       padding_ff, padding_in;
   logic       tail_ff, tail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha1s_pkg::S_IDLE;
         fill_ff     <= '0;
         round_ff    <= '0;
         len_ff      <= '0;
         idx_ff      <= '0;
         finished_ff <= 1'b0;
         error_ff    <= sha1s_pkg::STS_OK;
         padding_ff  <= 1'b0;
         tail_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         round_ff    <= round_in;
         len_ff      <= len_in;
         idx_ff      <= idx_in;
         finished_ff <= finished_in;
         error_ff    <= error_in;
         padding_ff  <= padding_in;
         tail_ff     <= tail_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      round_in    = round_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      finished_in = finished_ff;
      error_in    = error_ff;
      padding_in  = padding_ff;
      tail_in     = tail_ff;

      cmd            = '0;
      cmd.byte_sel   = sha1s_pkg::SEL_MSG;
      cmd.len_idx    = len_ff;
      cmd.rsp_index  = idx_ff;
      cmd.rsp_status = error_ff;
      if (round_ff < 7'd20) begin
         cmd.phase = 2'd0;
      end else if (round_ff < 7'd40) begin
         cmd.phase = 2'd1;
      end else if (round_ff < 7'd60) begin
         cmd.phase = 2'd2;
      end else begin
         cmd.phase = 2'd3;
      end

      unique case (state_ff)
         // Take one transaction and decode it
         sha1s_pkg::S_IDLE: begin
            if (req_accept) begin
               unique case (action)
                  sha1s_pkg::ACT_RESTART: begin
                     cmd.restart = 1'b1;
                     fill_in     = '0;
                     finished_in = 1'b0;
                     error_in    = sha1s_pkg::STS_OK;
                  end
                  sha1s_pkg::ACT_ABSORB: begin
                     if (finished_ff) begin
                        error_in = sha1s_pkg::STS_STATE_ERR;
                     end else if (error_ff == sha1s_pkg::STS_OK) begin
                        cmd.shift_en = 1'b1;
                        cmd.count_en = 1'b1;
                        fill_in      = fill_ff + 6'd1;
                        if (sts.count_top) begin
                           error_in = sha1s_pkg::STS_TOO_LONG;
                        end
                        if (fill_ff == sha1s_pkg::LAST_BYTE_POS) begin
                           cmd.load_vars = 1'b1;
                           round_in      = '0;
                           state_in      = sha1s_pkg::S_ROUND;
                        end
                     end
                  end
                  sha1s_pkg::ACT_FINISH: begin
                     if (error_ff != sha1s_pkg::STS_OK) begin
                        state_in = sha1s_pkg::S_EMIT_ERR;
                     end else if (finished_ff) begin
                        idx_in   = '0;
                        state_in = sha1s_pkg::S_EMIT;
                     end else begin
                        cmd.shift_en = 1'b1;
                        cmd.byte_sel = sha1s_pkg::SEL_PAD;
                        fill_in      = fill_ff + 6'd1;
                        padding_in   = 1'b1;
                        if (fill_ff == sha1s_pkg::LAST_BYTE_POS) begin
                           cmd.load_vars = 1'b1;
                           round_in      = '0;
                           state_in      = sha1s_pkg::S_ROUND;
                        end else begin
                           state_in = sha1s_pkg::S_PAD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Zero fill up to the length field
         sha1s_pkg::S_PAD: begin
            if (fill_ff == sha1s_pkg::LEN_FIELD_POS) begin
               len_in   = '0;
               state_in = sha1s_pkg::S_LEN;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = sha1s_pkg::SEL_ZERO;
               fill_in      = fill_ff + 6'd1;
               if (fill_ff == sha1s_pkg::LAST_BYTE_POS) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  state_in      = sha1s_pkg::S_ROUND;
               end
            end
         end
         // Append the bit count, most significant byte first
         sha1s_pkg::S_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = sha1s_pkg::SEL_LEN;
            fill_in      = fill_ff + 6'd1;
            len_in       = len_ff + 3'd1;
            if (len_ff == sha1s_pkg::LAST_LEN_BYTE) begin
               tail_in       = 1'b1;
               cmd.load_vars = 1'b1;
               round_in      = '0;
               state_in      = sha1s_pkg::S_ROUND;
            end
         end
         // One compression round per cycle
         sha1s_pkg::S_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == sha1s_pkg::LAST_ROUND) begin
               round_in = '0;
               state_in = sha1s_pkg::S_ADD;
            end
         end
         // Fold the block into the chaining value
         sha1s_pkg::S_ADD: begin
            cmd.add_chain = 1'b1;
            if (!padding_ff) begin
               state_in = sha1s_pkg::S_IDLE;
            end else if (tail_ff) begin
               cmd.count_clear = 1'b1;
               finished_in     = 1'b1;
               padding_in      = 1'b0;
               tail_in         = 1'b0;
               idx_in          = '0;
               state_in        = sha1s_pkg::S_EMIT;
            end else begin
               state_in = sha1s_pkg::S_PAD;
            end
         end
         // Hand out the five digest words
         sha1s_pkg::S_EMIT: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = sha1s_pkg::STS_OK;
               cmd.rsp_last   = (idx_ff == sha1s_pkg::LAST_WORD);
               idx_in         = idx_ff + 3'd1;
               if (idx_ff == sha1s_pkg::LAST_WORD) begin
                  idx_in   = '0;
                  state_in = sha1s_pkg::S_IDLE;
               end
            end
         end
         // Report the held error in place of the digest
         sha1s_pkg::S_EMIT_ERR: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_error = 1'b1;
               cmd.rsp_index = '0;
               cmd.rsp_last  = 1'b1;
               state_in      = sha1s_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sha1s_pkg::S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == sha1s_pkg::S_IDLE);

endmodule

// ===== src/sha1_stream_hasher_unit.sv =====
// Channel  Dir  Handshake            Payload
// req_     in   req_valid/req_ready  sha1s_pkg::req_type: action, data_byte
// rsp_     out  rsp_valid/rsp_ready  sha1s_pkg::rsp_type: digest_word, word_index, status, last
//
// A message byte is absorbed while idle; the byte that completes a block starts
// 80 rounds, then the chaining add, and no new byte is taken until they end.
// A first finish shifts in the pad, zero and length bytes (with an extra block
// if the length field no longer fits), compresses each block, then emits words.
// Reset is synchronous and loads the initial hash words. rsp_ready low holds
// digest emission; req_ready is high only while the controller is idle.
module sha1_stream_hasher_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sha1s_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sha1s_pkg::rsp_type rsp_payload
);

   sha1s_pkg::cmd_type cmd;
   sha1s_pkg::sts_type sts;
   logic               req_accept;

   assign req_accept = req_valid && req_ready;

   sha1s_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .action     (req_payload.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sha1s_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_payload.data_byte),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Error reports are single-word transactions
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != sha1s_pkg::STS_OK)
      |-> rsp_payload.last && (rsp_payload.word_index == 3'd0))
      else $error("error report not a single final word");

   // A successful digest ends on its fifth word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last && (rsp_payload.status == sha1s_pkg::STS_OK)
      |-> (rsp_payload.word_index == sha1s_pkg::LAST_WORD))
      else $error("digest ended early");

   // Digest words follow each other without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last
      |=> rsp_valid && (rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1))
      else $error("digest word sequence broken");

endmodule
